@@ sv/three_encoder_gyro_odometry_top_defines.svh @@
// Assertion macros for the odometry block
`ifndef THREE_ENCODER_GYRO_ODOMETRY_TOP_DEFINES_SVH
`define THREE_ENCODER_GYRO_ODOMETRY_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define AST_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define AST_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define AST_IMPL(lbl, a, c)
`define AST_NEXT(lbl, a, c)
`endif
`endif

@@ sv/tego_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Odometry package
// Types, register indexes, CORDIC constants and the arctangent table.
// ---------------------------------------------------------------------------
package tego_pkg;
  localparam int ATAN_LEN = 24;
  localparam logic signed [33:0] ANG_PI = 34'sd3373259426;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
  localparam logic signed [17:0] TH_PI = 18'sd25736;
  localparam logic signed [17:0] TH_TWO_PI = 18'sd51472;
  localparam logic [1:0] REG_IPT = 2'd0;
  localparam logic [1:0] REG_SX = 2'd1;
  localparam logic [1:0] REG_SY = 2'd2;
  localparam logic [1:0] REG_ST = 2'd3;

  typedef struct packed {
    logic load;      // latch input, form deltas
    logic scale;     // scaled distances
    logic cinit;     // set up CORDIC
    logic citer;     // one CORDIC step
    logic rot_a;     // negate CORDIC result if folded
    logic rot_b;     // all four products
    logic update;    // pose update
  } cmd_t;

  typedef struct packed {
    logic cordic_last;
  } sts_t;

  function automatic logic signed [33:0] atan_at(input logic [4:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0: r = 34'sd843314857;  5'd1: r = 34'sd497837830;
      5'd2: r = 34'sd263043837;  5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;   5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;   5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;    5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048576;   5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;    5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;     5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;     5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;       5'd23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // wrap a heading within two turns of the range by up to two adds or
  // subtracts of two pi
  function automatic logic signed [15:0] wrap_th(input logic signed [17:0] t);
    logic signed [17:0] r;
    r = t;
    if (r >= TH_PI) r = r - TH_TWO_PI;
    else if (r < -TH_PI) r = r + TH_TWO_PI;
    if (r >= TH_PI) r = r - TH_TWO_PI;
    else if (r < -TH_PI) r = r + TH_TWO_PI;
    return r[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

@@ sv/tego_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Odometry stream interfaces
// Valid/ready channels for samples and pose results.
// ---------------------------------------------------------------------------
interface tego_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] left_count;
  logic signed [31:0] back_count;
  logic signed [31:0] right_count;
  logic signed [15:0] yaw;
  modport source (output valid, left_count, back_count, right_count, yaw, input ready);
  modport sink (input valid, left_count, back_count, right_count, yaw, output ready);
endinterface

interface tego_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

@@ sv/tego_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Odometry controller
// Sequences load, distance, CORDIC iterations, rotation and pose update.
// ---------------------------------------------------------------------------
module tego_ctrl import tego_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0, S_DIST = 3'd1, S_CINIT = 3'd2,
    S_ITER = 3'd3, S_ROTA = 3'd4, S_ROTB = 3'd5, S_UPD = 3'd6;
  logic [2:0] state, state_next;
  logic       hold, hold_next;

  // result register frees before the update writes it
  assign in_ready = (state == S_IDLE);
  assign out_valid = hold;

  always_comb begin
    state_next = state;
    hold_next = hold && !out_ready;
    cmd = '0;
    unique case (state)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_next = S_DIST; end
      S_DIST: begin cmd.scale = 1'b1; state_next = S_CINIT; end
      S_CINIT: begin cmd.cinit = 1'b1; state_next = S_ITER; end
      S_ITER: begin
        cmd.citer = 1'b1;
        if (sts.cordic_last) state_next = S_ROTA;
      end
      S_ROTA: begin cmd.rot_a = 1'b1; state_next = S_ROTB; end
      S_ROTB: if (!hold_next) begin cmd.rot_b = 1'b1; state_next = S_UPD; end
      S_UPD: begin cmd.update = 1'b1; hold_next = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hold <= 1'b0;
    end else begin
      state <= state_next;
      hold <= hold_next;
    end
  end
endmodule

@@ sv/tego_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Odometry datapath
// Deltas, scaling, iterative CORDIC, rotation and saturating pose.
// ---------------------------------------------------------------------------
module tego_dp import tego_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] back_count,
  input  logic signed [31:0] right_count,
  input  logic signed [15:0] yaw,
  input  logic [23:0] inches_per_tick,
  input  logic load_x,
  input  logic load_y,
  input  logic load_t,
  input  logic signed [31:0] wdata,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [15:0] heading
);
  localparam int NS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  logic [31:0] last_l, last_b, last_r;
  logic signed [15:0] last_yaw, cur_yaw, dyaw_src;
  logic signed [32:0] dsum;
  logic signed [31:0] db;
  logic signed [31:0] fwd, lat;
  logic signed [33:0] cx, cy, cz;
  logic flip;
  logic [4:0] it;
  logic signed [63:0] p1, p2, p3, p4;
  logic signed [31:0] px, py;
  logic signed [15:0] pt;
  logic signed [33:0] z0;
  logic signed [31:0] dl, dr;

  assign dl = left_count - last_l;
  assign dr = right_count - last_r;
  assign z0 = {{1{yaw[15]}}, yaw, 17'd0};
  assign sts.cordic_last = (it == 5'(NS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      last_l <= '0; last_b <= '0; last_r <= '0; last_yaw <= '0;
      px <= '0; py <= '0; pt <= '0;
    end else begin
      if (cmd.load) begin
        dsum <= 33'(dl) + 33'(dr);
        db <= back_count - last_b;
        last_l <= left_count; last_b <= back_count; last_r <= right_count;
        dyaw_src <= last_yaw;
        last_yaw <= yaw;
        cur_yaw <= yaw;
        // prepare folded CORDIC angle
        if (z0 > ANG_HALF_PI) begin cz <= z0 - ANG_PI; flip <= 1'b1; end
        else if (z0 < -ANG_HALF_PI) begin cz <= z0 + ANG_PI; flip <= 1'b1; end
        else begin cz <= z0; flip <= 1'b0; end
      end
      if (cmd.scale) begin
        fwd <= sat32(64'(($signed(65'(dsum)) * $signed({1'b0, inches_per_tick})) >>> 9));
        lat <= sat32(64'(($signed(65'(db)) * $signed({1'b0, inches_per_tick})) >>> 8));
      end
      if (cmd.cinit) begin
        cx <= CORDIC_GAIN; cy <= '0; it <= '0;
      end
      if (cmd.citer) begin
        if (!cz[33]) begin
          cx <= cx - (cy >>> it); cy <= cy + (cx >>> it); cz <= cz - atan_at(it);
        end else begin
          cx <= cx + (cy >>> it); cy <= cy - (cx >>> it); cz <= cz + atan_at(it);
        end
        it <= it + 5'd1;
      end
      if (cmd.rot_a) begin
        if (flip) begin cx <= -cx; cy <= -cy; end
      end
      if (cmd.rot_b) begin
        p1 <= 64'(fwd) * 64'(cx); p2 <= 64'(lat) * 64'(cy);
        p3 <= 64'(fwd) * 64'(cy); p4 <= 64'(lat) * 64'(cx);
      end
      if (cmd.update) begin
        px <= sat32(64'(px) + ((p1 - p2) >>> 30));
        py <= sat32(64'(py) + ((p3 + p4) >>> 30));
        pt <= wrap_th(18'(pt) + 18'(cur_yaw) - 18'(dyaw_src));
      end
      if (load_x) px <= wdata;
      if (load_y) py <= wdata;
      if (load_t) pt <= wrap_th(18'($signed(wdata[15:0])));
    end
  end

  assign pos_x = px;
  assign pos_y = py;
  assign heading = pt;
endmodule

@@ sv/three_encoder_gyro_odometry_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Three-encoder gyro odometry
// Dead reckoning from encoder counts and gyro yaw.
// ---------------------------------------------------------------------------
// channel  dir  handshake
// smp      in   valid/ready
// pose     out  valid/ready
// apb      in   psel/penable, pready high
// A sample runs through load, scaling, CORDIC set-up, the iterative CORDIC, fold, products and update.
// Reset clears counts and pose; the next sample waits while a result stalls.
`include "three_encoder_gyro_odometry_top_defines.svh"
module three_encoder_gyro_odometry_top import tego_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  tego_in_if.sink smp,
  tego_out_if.source pose,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  cmd_t cmd;
  sts_t sts;
  logic [23:0] ipt;
  logic [31:0] sx, sy;
  logic [15:0] st;
  logic wr;
  logic [1:0] ra;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ra = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      ipt <= 24'd16777; sx <= '0; sy <= '0; st <= '0;
    end else if (wr && paddr[1:0] == 2'd0) begin
      unique case (ra)
        REG_IPT: ipt <= pwdata[23:0];
        REG_SX: sx <= pwdata;
        REG_SY: sy <= pwdata;
        REG_ST: st <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ra)
      REG_IPT: prdata = {8'd0, ipt};
      REG_SX: prdata = sx;
      REG_SY: prdata = sy;
      REG_ST: prdata = {16'd0, st};
      default: prdata = '0;
    endcase
  end

  tego_ctrl u_ctrl (
    .clk, .rst, .in_valid(smp.valid), .in_ready(smp.ready),
    .out_valid(pose.valid), .out_ready(pose.ready), .sts, .cmd
  );

  tego_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .left_count(smp.left_count), .back_count(smp.back_count),
    .right_count(smp.right_count), .yaw(smp.yaw),
    .inches_per_tick(ipt),
    .load_x(wr && paddr[1:0] == 2'd0 && ra == REG_SX),
    .load_y(wr && paddr[1:0] == 2'd0 && ra == REG_SY),
    .load_t(wr && paddr[1:0] == 2'd0 && ra == REG_ST),
    .wdata(pwdata),
    .pos_x(pose.pos_x), .pos_y(pose.pos_y), .heading(pose.heading)
  );

  `AST_IMPL(a_no_accept_busy, cmd.citer, !smp.ready)
  `AST_NEXT(a_upd_valid, cmd.update, pose.valid)
  `AST_IMPL(a_one_cmd, 1'b1, $onehot0(cmd))
endmodule
